### rtl/cscan_pkg.sv
package cscan_pkg;

	// Stream field widths
	localparam int REQ_W     = 4;
	localparam int TRK_W     = 16;
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 3;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TRACK_BITS_DEF  = 16;

	// req_type codes
	localparam logic REQ_DISK    = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef struct packed {
		logic load_in;
		logic grant_idle;
		logic cnt_clr;
		logic cnt_inc;
		logic alloc;
		logic drop;
		logic scan_clr;
		logic scan_en;
		logic pick;
		logic fix_en;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic in_release;
		logic busy;
		logic slot_free;
		logic cnt_last;
		logic out_free;
		logic any_found;
	} sts_t;

endpackage

### rtl/cscan_ram.sv
module cscan_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/cscan_ctrl.sv
module cscan_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  cscan_pkg::sts_t sts,
	output cscan_pkg::cmd_t cmd
);
	import cscan_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FIND,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_RESULT,
		ST_FIX,
		ST_FIX_END
	} state_t;

	state_t state_q, state_nxt;
	logic   rdy_q;
	logic   fix_pend_q;

	assign s_tready = rdy_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.in_release) begin
					cmd.cnt_clr  = 1'b1;
					cmd.scan_clr = 1'b1;
					state_nxt    = ST_SCAN;
				end else if (!sts.busy) begin
					cmd.grant_idle = 1'b1;
					state_nxt      = ST_RESULT;
				end else begin
					cmd.cnt_clr = 1'b1;
					state_nxt   = ST_FIND;
				end
			end
			ST_FIND: begin
				if (sts.slot_free) begin
					cmd.alloc = 1'b1;
					state_nxt = ST_RESULT;
				end else if (sts.cnt_last) begin
					cmd.drop  = 1'b1;
					state_nxt = ST_RESULT;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_nxt = ST_SCAN_END;
				end
			end
			// last read of the scan still in the compare stage
			ST_SCAN_END: begin
				state_nxt = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick  = 1'b1;
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					if (fix_pend_q) begin
						cmd.cnt_clr = 1'b1;
						state_nxt   = ST_FIX;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_FIX: begin
				cmd.fix_en  = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_nxt = ST_FIX_END;
				end
			end
			ST_FIX_END: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rdy_q      <= 1'b1;
			fix_pend_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rdy_q   <= (state_nxt == ST_IDLE);
			if (cmd.load_in) begin
				fix_pend_q <= 1'b0;
			end else if (cmd.pick) begin
				// a granted waiter leaves a hole in the arrival ranks
				fix_pend_q <= sts.any_found;
			end
		end
	end

endmodule

### rtl/cscan_dp.sv
module cscan_dp #(
	parameter int QUEUE_DEPTH = cscan_pkg::QUEUE_DEPTH_DEF,
	parameter int TRACK_BITS  = cscan_pkg::TRACK_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cscan_pkg::cmd_t             cmd,
	output cscan_pkg::sts_t             sts,
	input  logic                        in_req_type,
	input  logic [cscan_pkg::REQ_W-1:0] in_requester,
	input  logic [cscan_pkg::TRK_W-1:0] in_track,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_grant,
	output logic [cscan_pkg::REQ_W-1:0] out_requester,
	output logic [cscan_pkg::TRK_W-1:0] out_track,
	output logic                        out_dropped,
	output logic                        out_busy
);
	import cscan_pkg::*;

	localparam int IW  = $clog2(QUEUE_DEPTH);
	localparam int RKW = IW;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int DW  = TRACK_BITS + REQ_W + RKW;
	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

	// item and scheduler state
	logic                   in_type_q;
	logic [REQ_W-1:0]       in_req_q;
	logic [TRACK_BITS-1:0]  in_trk_q;
	logic                   busy_q;
	logic [TRACK_BITS-1:0]  cur_q;
	logic [CW-1:0]          count_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [QUEUE_DEPTH-1:0] down_q;
	logic [IW-1:0]          cnt_q;

	// read stage
	logic                   rd_scan_s1, rd_fix_s1;
	logic                   rd_vld_s1, rd_down_s1;
	logic [IW-1:0]          rd_idx_s1;
	logic [DW-1:0]          ram_rdata;
	logic [TRACK_BITS-1:0]  rd_trk;
	logic [REQ_W-1:0]       rd_req;
	logic [RKW-1:0]         rd_rank;

	// best candidates: upward only, and any waiter
	logic                   bu_found_q, ba_found_q;
	logic [IW-1:0]          bu_idx_q, ba_idx_q;
	logic [TRACK_BITS-1:0]  bu_trk_q, ba_trk_q;
	logic [REQ_W-1:0]       bu_req_q, ba_req_q;
	logic [RKW-1:0]         bu_rank_q, ba_rank_q;
	logic                   up_better, any_better;

	logic [IW-1:0]          sel_idx;
	logic [TRACK_BITS-1:0]  sel_trk;
	logic [REQ_W-1:0]       sel_req;
	logic [RKW-1:0]         sel_rank;
	logic [RKW-1:0]         fix_rank_q;

	logic                   res_grant_q, res_dropped_q, res_busy_q;
	logic [REQ_W-1:0]       res_req_q;
	logic [TRACK_BITS-1:0]  res_trk_q;

	logic                   out_valid_q;
	logic                   out_grant_q, out_dropped_q, out_busy_q;
	logic [REQ_W-1:0]       out_req_q;
	logic [TRACK_BITS-1:0]  out_trk_q;

	logic                   fix_wr;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [DW-1:0]          ram_wdata;

	assign rd_trk  = ram_rdata[TRACK_BITS-1:0];
	assign rd_req  = ram_rdata[TRACK_BITS +: REQ_W];
	assign rd_rank = ram_rdata[TRACK_BITS+REQ_W +: RKW];

	assign any_better = !ba_found_q || (rd_trk < ba_trk_q) ||
		((rd_trk == ba_trk_q) && (rd_rank < ba_rank_q));
	assign up_better  = !bu_found_q || (rd_trk < bu_trk_q) ||
		((rd_trk == bu_trk_q) && (rd_rank < bu_rank_q));

	// no upward waiter: every waiter turns upward, so the best of all wins
	assign sel_idx  = bu_found_q ? bu_idx_q  : ba_idx_q;
	assign sel_trk  = bu_found_q ? bu_trk_q  : ba_trk_q;
	assign sel_req  = bu_found_q ? bu_req_q  : ba_req_q;
	assign sel_rank = bu_found_q ? bu_rank_q : ba_rank_q;

	// rank compaction: every later waiter moves down by one
	assign fix_wr    = rd_fix_s1 && rd_vld_s1 && (rd_rank > fix_rank_q);
	assign ram_we    = cmd.alloc || fix_wr;
	assign ram_waddr = cmd.alloc ? cnt_q : rd_idx_s1;
	assign ram_wdata = cmd.alloc ? {RKW'(count_q), in_req_q, in_trk_q}
	                             : {rd_rank - RKW'(1), rd_req, rd_trk};

	cscan_ram #(
		.WIDTH(DW),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts            = '0;
		sts.in_release = (in_type_q == REQ_RELEASE);
		sts.busy       = busy_q;
		sts.slot_free  = !valid_q[cnt_q];
		sts.cnt_last   = (cnt_q == LAST_IDX);
		sts.out_free   = !out_valid_q || out_ready;
		sts.any_found  = ba_found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cur_q       <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_scan_s1  <= 1'b0;
			rd_fix_s1   <= 1'b0;
			bu_found_q  <= 1'b0;
			ba_found_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_scan_s1 <= cmd.scan_en;
			rd_fix_s1  <= cmd.fix_en;

			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
			end

			if (cmd.grant_idle) begin
				busy_q <= 1'b1;
				cur_q  <= in_trk_q;
			end

			if (cmd.alloc) begin
				valid_q[cnt_q] <= 1'b1;
				count_q        <= count_q + CW'(1);
			end

			if (cmd.scan_clr) begin
				bu_found_q <= 1'b0;
				ba_found_q <= 1'b0;
			end else if (rd_scan_s1 && rd_vld_s1) begin
				if (any_better) begin
					ba_found_q <= 1'b1;
				end
				if (!rd_down_s1 && up_better) begin
					bu_found_q <= 1'b1;
				end
			end

			if (cmd.pick) begin
				if (ba_found_q) begin
					cur_q            <= sel_trk;
					valid_q[sel_idx] <= 1'b0;
					count_q          <= count_q - CW'(1);
				end else begin
					busy_q <= 1'b0;
					cur_q  <= '0;
				end
			end

			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_type_q <= in_req_type;
			in_req_q  <= in_requester;
			in_trk_q  <= TRACK_BITS'(in_track);
		end

		if (cmd.alloc) begin
			down_q[cnt_q] <= (in_trk_q < cur_q);
		end else if (cmd.pick && !bu_found_q) begin
			down_q <= '0;
		end

		rd_idx_s1  <= cnt_q;
		rd_vld_s1  <= valid_q[cnt_q];
		rd_down_s1 <= down_q[cnt_q];

		if (rd_scan_s1 && rd_vld_s1 && !cmd.scan_clr) begin
			if (any_better) begin
				ba_idx_q  <= rd_idx_s1;
				ba_trk_q  <= rd_trk;
				ba_req_q  <= rd_req;
				ba_rank_q <= rd_rank;
			end
			if (!rd_down_s1 && up_better) begin
				bu_idx_q  <= rd_idx_s1;
				bu_trk_q  <= rd_trk;
				bu_req_q  <= rd_req;
				bu_rank_q <= rd_rank;
			end
		end

		if (cmd.grant_idle) begin
			res_grant_q   <= 1'b1;
			res_req_q     <= in_req_q;
			res_trk_q     <= in_trk_q;
			res_dropped_q <= 1'b0;
			res_busy_q    <= 1'b1;
		end else if (cmd.alloc || cmd.drop) begin
			res_grant_q   <= 1'b0;
			res_req_q     <= '0;
			res_trk_q     <= '0;
			res_dropped_q <= cmd.drop;
			res_busy_q    <= busy_q;
		end else if (cmd.pick) begin
			res_grant_q   <= ba_found_q;
			res_req_q     <= ba_found_q ? sel_req : '0;
			res_trk_q     <= ba_found_q ? sel_trk : '0;
			res_dropped_q <= 1'b0;
			res_busy_q    <= ba_found_q ? busy_q : 1'b0;
			fix_rank_q    <= sel_rank;
		end

		if (cmd.res_load) begin
			out_grant_q   <= res_grant_q;
			out_req_q     <= res_req_q;
			out_trk_q     <= res_trk_q;
			out_dropped_q <= res_dropped_q;
			out_busy_q    <= res_busy_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_grant     = out_grant_q;
	assign out_requester = out_req_q;
	assign out_track     = TRK_W'(out_trk_q);
	assign out_dropped   = out_dropped_q;
	assign out_busy      = out_busy_q;

endmodule

### rtl/cscan_track_request_arbiter_top.sv
// C-SCAN disk arbiter, one item at a time, one result item per input item.
// Request on an idle disk: granted at once from the input register, no search.
// Request on a busy disk: free-slot search, then a queued or dropped result.
// Release: scan with one slot-RAM read per cycle, pick, result, then (if a
// waiter was granted) a rank compaction pass over the RAM before the next item.
// arst_n clears the disk to idle, current track 0 and all slots free.
module cscan_track_request_arbiter_top #(
	parameter int QUEUE_DEPTH = cscan_pkg::QUEUE_DEPTH_DEF,
	parameter int TRACK_BITS  = cscan_pkg::TRACK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cscan_pkg::S_TDATA_W-1:0] s_tdata,  // requester, track, zero pad
	input  logic [cscan_pkg::S_TUSER_W-1:0] s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cscan_pkg::M_TDATA_W-1:0] m_tdata,  // grant_requester, grant_track, zero pad
	output logic [cscan_pkg::M_TUSER_W-1:0] m_tuser   // grant_valid, dropped, disk_busy
);
	import cscan_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic             grant;
	logic             dropped;
	logic             busy;
	logic [REQ_W-1:0] grant_req;
	logic [TRK_W-1:0] grant_trk;

	cscan_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cscan_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TRACK_BITS (TRACK_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_req_type   (s_tuser[0]),
		.in_requester  (s_tdata[REQ_W-1:0]),
		.in_track      (s_tdata[REQ_W +: TRK_W]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_grant     (grant),
		.out_requester (grant_req),
		.out_track     (grant_trk),
		.out_dropped   (dropped),
		.out_busy      (busy)
	);

	assign m_tdata = {{(M_TDATA_W - REQ_W - TRK_W){1'b0}}, grant_trk, grant_req};
	assign m_tuser = {busy, dropped, grant};

endmodule

### rtl/cscan_checker.sv
module cscan_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cscan_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [cscan_pkg::M_TUSER_W-1:0] m_tuser
);
	import cscan_pkg::*;

	// one item at a time: input closes right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[REQ_W+TRK_W-1:0] == '0))
		else $error("grant fields set without a grant");

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tuser[2])
		else $error("drop reported with grant or on idle disk");

	a_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2])
		else $error("grant reported with disk idle");

endmodule

bind cscan_track_request_arbiter_top cscan_checker u_cscan_checker (.*);
